// ===== design/kmee_pkg.sv =====
// ============================================================================
// kmee_pkg: shared types and constants of the keypad matrix event encoder
// Holds the key table size, event and command codes and register indexes.
// ============================================================================
package kmee_pkg;

  localparam int KEYS  = 16;
  localparam int KEY_W = 16;
  localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;

  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 5;
  localparam int POS_W   = 4;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [COUNT_W-1:0] KEY_COUNT_RESET = COUNT_W'(16);

  localparam logic REG_KEY_COUNT = 1'b0;

  localparam logic CMD_SCAN  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_UP   = 2'd2
  } event_kind_t;

endpackage

// ===== design/keypad_matrix_event_encoder.sv =====
// ============================================================================
// keypad_matrix_event_encoder: key matrix snapshot to key event encoder
// Compares each scan snapshot with the pressed map, reports the lowest
// changed key with its keymap character and updates that one bit.
// ============================================================================
//
//   Port group   Handshake              Carries
//   ----------   --------------------   ------------------------------------
//   request      req_valid/req_ready    command, scan_bits, map_index, map_char
//   response     rsp_valid/rsp_ready    event_kind, key_index, key_char
//   config       APB psel/penable       key_count at byte address 0
//
// One request is taken every cycle while req_ready is high; a scan response
// passes through the keymap memory read stage and then the output register.
// The pressed map updates in the cycle a scan is taken.
// Reset clears the pressed map and the keymap valid bits.
// A stalled response holds the output register, then the read stage, and
// only then drops req_ready; write requests never produce a response.
module keypad_matrix_event_encoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kmee_pkg::ADDR_W-1:0]     paddr,
  input  logic [kmee_pkg::DATA_W-1:0]     pwdata,
  output logic [kmee_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic                            command,
  input  logic [kmee_pkg::KEY_W-1:0]      scan_bits,
  input  logic [kmee_pkg::POS_W-1:0]      map_index,
  input  logic [kmee_pkg::CHAR_W-1:0]     map_char,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output kmee_pkg::event_kind_t           event_kind,
  output logic [kmee_pkg::POS_W-1:0]      key_index,
  output logic [kmee_pkg::CHAR_W-1:0]     key_char
);
  import kmee_pkg::*;

  logic [COUNT_W-1:0] key_count;
  logic [KEY_W-1:0]   pressed_map;
  logic [KEY_W-1:0]   pressed_map_next;

  logic [CHAR_W-1:0]  keymap_mem [KEYS];
  logic [KEYS-1:0]    keymap_vld;
  logic [CHAR_W-1:0]  rd_data;
  logic               rd_vld;

  logic               s1_valid;
  event_kind_t        s1_kind;
  logic [POS_W-1:0]   s1_index;
  logic               s1_in_tbl;

  event_kind_t        out_kind;
  logic [POS_W-1:0]   out_index;
  logic [CHAR_W-1:0]  out_char;

  logic               cfg_wr;
  logic               acc;
  logic               acc_scan;
  logic               acc_write;
  logic               out_free;
  logic               s1_adv;
  logic [COUNT_W-1:0] act_count;
  logic [KEY_W-1:0]   act_mask;
  logic [KEY_W-1:0]   diff;
  logic               hit;
  logic [POS_W-1:0]   pos;
  logic               pos_in_tbl;
  event_kind_t        kind;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_in_tbl;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_KEY_COUNT) ? DATA_W'(key_count) : '0;

  assign out_free  = !rsp_valid || rsp_ready;
  assign s1_adv    = s1_valid && out_free;
  assign req_ready = !s1_valid || out_free;
  assign acc       = req_valid && req_ready;
  assign acc_scan  = acc && (command == CMD_SCAN);
  assign acc_write = acc && (command == CMD_WRITE);

  always_comb begin
    act_count = (key_count > COUNT_W'(KEY_W)) ? COUNT_W'(KEY_W) : key_count;
    if (act_count > COUNT_W'(KEYS)) begin
      act_count = COUNT_W'(KEYS);
    end
    for (int i = 0; i < KEY_W; i++) begin
      act_mask[i] = (COUNT_W'(i) < act_count);
    end
    diff = (scan_bits ^ pressed_map) & act_mask;
    hit  = |diff;
    pos  = '0;
    for (int i = KEY_W - 1; i >= 0; i--) begin
      if (diff[i]) begin
        pos = POS_W'(i);
      end
    end
    pos_in_tbl = (int'(pos) < KEYS);
    rd_addr    = IDX_W'(pos);
    if (!hit) begin
      kind = EV_NONE;
    end else if (scan_bits[pos]) begin
      kind = EV_DOWN;
    end else begin
      kind = EV_UP;
    end
    pressed_map_next = pressed_map;
    if (acc_scan && hit) begin
      pressed_map_next[pos] = scan_bits[pos];
    end
    wr_in_tbl = (int'(map_index) < KEYS);
    wr_addr   = IDX_W'(map_index);
  end

  always_ff @(posedge clk) begin
    if (acc_write && wr_in_tbl) begin
      keymap_mem[wr_addr] <= map_char;
    end
    if (acc_scan) begin
      rd_data   <= keymap_mem[rd_addr];
      rd_vld    <= keymap_vld[rd_addr];
      s1_kind   <= kind;
      s1_index  <= pos;
      s1_in_tbl <= pos_in_tbl;
    end
    if (s1_adv) begin
      out_kind  <= s1_kind;
      out_index <= s1_index;
      out_char  <= (s1_kind != EV_NONE && s1_in_tbl && rd_vld) ? rd_data : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count   <= KEY_COUNT_RESET;
      pressed_map <= '0;
      keymap_vld  <= '0;
      s1_valid    <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_KEY_COUNT) begin
        key_count <= pwdata[COUNT_W-1:0];
      end
      pressed_map <= pressed_map_next;
      if (acc_write && wr_in_tbl) begin
        keymap_vld[wr_addr] <= 1'b1;
      end
      if (acc_scan) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  assign event_kind = out_kind;
  assign key_index  = out_index;
  assign key_char   = out_char;

  a_no_event_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && event_kind == EV_NONE |-> key_index == '0 && key_char == '0)
    else $error("no-change response carries a key");

  a_one_bit_flip: assert property (@(posedge clk) disable iff (rst)
    acc_scan && hit |=> $countones(pressed_map ^ $past(pressed_map)) == 1)
    else $error("scan event did not flip exactly one pressed bit");

  a_map_stable: assert property (@(posedge clk) disable iff (rst)
    !acc_scan |=> $stable(pressed_map))
    else $error("pressed map changed without a scan");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(rd_vld) && $stable(s1_index))
    else $error("read stage lost its contents while stalled");

endmodule

// ===== bench/kmee_checker.sv =====
// ============================================================================
// kmee_checker: scoreboard for the keypad matrix event encoder
// Watches the configuration port and the request and response channels, predicts the
// key event of every scan request and compares it with the block's response.
// ============================================================================
module kmee_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kmee_pkg::ADDR_W-1:0]     paddr,
  input  logic [kmee_pkg::DATA_W-1:0]     pwdata,
  input  logic                            pready,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  logic                            command,
  input  logic [kmee_pkg::KEY_W-1:0]      scan_bits,
  input  logic [kmee_pkg::POS_W-1:0]      map_index,
  input  logic [kmee_pkg::CHAR_W-1:0]     map_char,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  kmee_pkg::event_kind_t           event_kind,
  input  logic [kmee_pkg::POS_W-1:0]      key_index,
  input  logic [kmee_pkg::CHAR_W-1:0]     key_char,
  output int                              mismatches,
  output int                              pending,
  output int                              downs,
  output int                              ups
);
  timeunit 1ns;
  timeprecision 1ps;
  import kmee_pkg::*;

  localparam logic [ADDR_W-1:0] KEY_COUNT_ADDR = ADDR_W'(4 * REG_KEY_COUNT);

  typedef struct packed {
    event_kind_t         kind;
    logic [POS_W-1:0]    index;
    logic [CHAR_W-1:0]   code;
  } key_event_t;

  logic [KEY_W-1:0]   pressed_map;
  logic [CHAR_W-1:0]  keymap [KEYS];
  logic [COUNT_W-1:0] key_count;
  key_event_t         pending_events [$];

  function automatic key_event_t encode_scan(input logic [KEY_W-1:0] snap);
    key_event_t ev;
    int         active;
    int         pos;
    bit         found;
    ev = '0;
    found = 0;
    active = key_count;
    if (active > KEYS) active = KEYS;
    if (active > KEY_W) active = KEY_W;
    for (pos = 0; pos < active && !found; pos++) begin
      if (snap[pos] != pressed_map[pos]) begin
        found = 1;
        ev.kind = snap[pos] ? EV_DOWN : EV_UP;
        ev.index = POS_W'(pos);
        ev.code = keymap[pos];
        pressed_map[pos] = snap[pos];
      end
    end
    return ev;
  endfunction

  task automatic log_failure(input string what, input key_event_t want,
                             input key_event_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected kind %0d index %0d char %02h, %s %0d index %0d char %02h",
               $realtime, what, want.kind, want.index, want.code, "got kind",
               got.kind, got.index, got.code);
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    downs = 0;
    ups = 0;
  end

  always @(posedge clk) begin
    key_event_t got;
    key_event_t want;
    if (rst) begin
      pressed_map = '0;
      foreach (keymap[i]) keymap[i] = '0;
      key_count = KEY_COUNT_RESET;
      pending_events.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == KEY_COUNT_ADDR)
        key_count = pwdata[COUNT_W-1:0];
      if (rsp_valid && rsp_ready) begin
        got.kind = event_kind;
        got.index = key_index;
        got.code = key_char;
        if (got.kind == EV_DOWN) downs++;
        if (got.kind == EV_UP) ups++;
        if (pending_events.size() == 0) begin
          log_failure("response with no scan request pending", '0, got);
        end else begin
          want = pending_events.pop_front();
          if (got.kind !== want.kind || got.index !== want.index || got.code !== want.code)
            log_failure("key event mismatch", want, got);
        end
      end
      if (req_valid && req_ready) begin
        if (command == CMD_WRITE) begin
          if (map_index < KEYS) keymap[map_index] = map_char;
        end else begin
          pending_events.push_back(encode_scan(scan_bits));
        end
      end
    end
    pending = pending_events.size();
  end

endmodule

// ===== bench/tb.sv =====
// ============================================================================
// tb: testbench of the keypad matrix event encoder
// Drives directed and random scan and keymap requests under several key
// counts, with random gaps and response stalls, and reports the verdict.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kmee_pkg::*;

  localparam logic [ADDR_W-1:0] KEY_COUNT_ADDR = ADDR_W'(4 * REG_KEY_COUNT);

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               req_valid;
  logic               req_ready;
  logic               command;
  logic [KEY_W-1:0]   scan_bits;
  logic [POS_W-1:0]   map_index;
  logic [CHAR_W-1:0]  map_char;
  logic               rsp_valid;
  logic               rsp_ready;
  event_kind_t        event_kind;
  logic [POS_W-1:0]   key_index;
  logic [CHAR_W-1:0]  key_char;

  int mismatches;
  int pending;
  int downs;
  int ups;

  bit calm;
  int scans_sent;
  int writes_sent;
  int settings_used;

  keypad_matrix_event_encoder dut (.*);

  kmee_checker scoreboard (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rsp_ready = 0;
    forever begin
      @(negedge clk);
      rsp_ready <= calm || ($urandom_range(0, 99) >= 9);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input logic cmd, input logic [KEY_W-1:0] bits,
                          input logic [POS_W-1:0] idx, input logic [CHAR_W-1:0] ch);
    while (!calm && $urandom_range(0, 99) < 9) begin
      req_valid <= 0;
      @(negedge clk);
    end
    req_valid <= 1;
    command <= cmd;
    scan_bits <= bits;
    map_index <= idx;
    map_char <= ch;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
    if (cmd == CMD_WRITE) writes_sent++;
    else scans_sent++;
  endtask

  task automatic scan(input logic [KEY_W-1:0] bits);
    send_req(CMD_SCAN, bits, POS_W'($urandom), CHAR_W'($urandom));
  endtask

  task automatic write_key(input logic [POS_W-1:0] idx, input logic [CHAR_W-1:0] ch);
    send_req(CMD_WRITE, KEY_W'($urandom), idx, ch);
  endtask

  // Writes the key count once the block has drained every request.
  task automatic set_key_count(input logic [DATA_W-1:0] value);
    req_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= KEY_COUNT_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    settings_used++;
  endtask

  initial begin
    logic [DATA_W-1:0] counts [7];
    logic [KEY_W-1:0]  target;
    int                done;
    int                steps;
    int                pick;

    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    req_valid = 0;
    command = CMD_SCAN;
    scan_bits = '0;
    map_index = '0;
    map_char = '0;
    calm = 0;
    scans_sent = 0;
    writes_sent = 0;
    settings_used = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    scan(16'h0000);
    write_key(4'd0, 8'hFF);
    write_key(4'd15, 8'h80);
    write_key(4'd1, 8'h01);
    scan(16'hFFFF);
    scan(16'h8000);
    scan(16'h8000);
    scan(16'h8000);
    send_req(CMD_SCAN, 16'h0000, 4'hF, 8'hFF);
    set_key_count(32'd0);
    scan(16'hFFFF);
    set_key_count(32'd1);
    scan(16'hFFFF);
    scan(16'hFFFF);
    scan(16'hFFFE);
    set_key_count(32'hFFFF_FFFF);
    scan(16'h0002);
    scan(16'h0000);
    scan(16'h5555);
    send_req(CMD_SCAN, 16'h5555, 4'h0, 8'h00);

    counts = '{32'd16, DATA_W'($urandom_range(2, 15)), 32'd1, 32'd31, 32'd0,
               DATA_W'($urandom_range(2, 15)), 32'd16};
    foreach (counts[p]) begin
      set_key_count(counts[p]);
      calm = (p == 2);
      done = 0;
      while (done < 65) begin
        if (p == 4 && done >= 30 && done < 40) begin
          req_valid <= 0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
          done = 40;
        end
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          write_key(POS_W'($urandom), CHAR_W'($urandom));
          done++;
        end else if (pick < 25) begin
          scan(KEY_W'($urandom));
          done++;
        end else begin
          case ($urandom_range(0, 2))
            0: target = KEY_W'($urandom & $urandom & $urandom);
            1: target = KEY_W'($urandom | $urandom);
            default: target = KEY_W'($urandom);
          endcase
          steps = $urandom_range(1, 18);
          if (steps > 65 - done) steps = 65 - done;
          repeat (steps) scan(target);
          done += steps;
        end
      end
    end
    calm = 0;

    req_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d scan and %0d keymap write requests under %0d key-count settings.",
             scans_sent, writes_sent, settings_used);
    $display("Responses carried %0d key-down and %0d key-up events; %0d mismatches.",
             downs, ups, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/kmee_pkg.sv
design/keypad_matrix_event_encoder.sv
bench/kmee_checker.sv
bench/tb.sv
